FILE: rtl/core/tktm_pkg.sv
// Shared constants for the touch-key trimmed-mean detector.
`timescale 1ns / 1ps

package tktm_pkg;

  // Sample field width on the ports and the number of sample bits kept.
  localparam int TIME_W      = 32;
  localparam int SAMPLE_BITS = 32;

  // Group bookkeeping.
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] GROUP_LAST = CNT_W'(9);  // tenth sample closes a group
  localparam logic [CNT_W-1:0] GROUP_SIZE = CNT_W'(10);

  // Sum of ten samples fits in 36 bits without wrapping.
  localparam int SUM_W = 36;

  // Divide by eight after trimming.
  localparam int TRIM_SHIFT = 3;

  localparam logic [TIME_W-1:0] MIN_RESET = {TIME_W{1'b1}};

  // floor(b / 10) == (b * RECIP_TEN) >> RECIP_SHIFT for every 32-bit b.
  localparam logic [TIME_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int                RECIP_SHIFT = 35;
  localparam int                PROD_W      = 2 * TIME_W;

  // Threshold width: baseline plus a tenth never wraps at 33 bits.
  localparam int LIMIT_W = TIME_W + 1;

endpackage

FILE: rtl/core/touch_key_trimmed_mean_detector.sv
// Touch-key trimmed-mean detector: group filter, baseline and touch decision.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid / in_stall): one beat carries one charge-time
//   sample in in_sample_time, or a missed capture flagged by in_missed.
//   A missed beat drops the group in progress and yields no result.
// - Every tenth good sample closes a group: min and max are trimmed, the
//   remaining eight are averaged (divide by 8, round down).
// - Result channel (out_valid / out_stall): one beat per closed group with
//   out_filtered_time, out_is_baseline (first group after reset, stored as
//   the untouched baseline) and out_touched (mean above baseline + 1/10).
// - Throughput: one input beat per cycle while in_stall is low. The group
//   accumulator updates at the accept edge; the closing beat's totals go to
//   the stage A register, then the trimmed sum to stage B, then the output
//   register, which drives the ports.
// - Reset (rst_n low, synchronous): the group is cleared, the baseline is
//   forgotten and all pipeline stages are emptied.
// - Receiver stall: the output register holds its beat; the stages behind
//   it keep filling until a closed group has no free slot, and only then
//   is in_stall raised.

module touch_key_trimmed_mean_detector (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tktm_pkg::TIME_W-1:0] in_sample_time,
  input  logic                        in_missed,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tktm_pkg::TIME_W-1:0] out_filtered_time,
  output logic                        out_is_baseline,
  output logic                        out_touched
);

  // Group accumulator.
  logic [tktm_pkg::CNT_W-1:0]   sample_count_r, sample_count_nxt;
  logic [tktm_pkg::TIME_W-1:0]  group_min_r, group_min_nxt;
  logic [tktm_pkg::TIME_W-1:0]  group_max_r, group_max_nxt;
  logic [tktm_pkg::SUM_W-1:0]   group_sum_r, group_sum_nxt;

  // Closed group waiting for trim (stage A).
  logic                         a_valid_r, a_valid_nxt;
  logic [tktm_pkg::TIME_W-1:0]  a_min_r, a_max_r;
  logic [tktm_pkg::SUM_W-1:0]   a_sum_r;

  // Trimmed sum (stage B).
  logic                         b_valid_r, b_valid_nxt;
  logic [tktm_pkg::SUM_W-1:0]   b_trim_r;

  // Output register.
  logic                         out_valid_r, out_valid_nxt;
  logic [tktm_pkg::TIME_W-1:0]  out_time_r;
  logic                         out_base_r;
  logic                         out_touch_r;

  // Baseline and its touch threshold.
  logic                         calibrated_r;
  logic [tktm_pkg::TIME_W-1:0]  baseline_r;
  logic [tktm_pkg::PROD_W-1:0]  tenth_prod_r;
  logic [tktm_pkg::LIMIT_W-1:0] limit_r;

  logic                         c_ready, b_move, b_free, a_move, a_free;
  logic                         in_fire, good_fire, group_done;
  logic [tktm_pkg::TIME_W-1:0]  sample;
  logic [tktm_pkg::TIME_W-1:0]  upd_min, upd_max;
  logic [tktm_pkg::SUM_W-1:0]   upd_sum;
  logic [tktm_pkg::TIME_W-1:0]  mean;

  // Flow control: each stage advances when the one ahead has room.
  assign c_ready   = !out_valid_r || !out_stall;
  assign b_move    = b_valid_r && c_ready;
  assign b_free    = !b_valid_r || c_ready;
  assign a_move    = a_valid_r && b_free;
  assign a_free    = !a_valid_r || b_free;
  assign in_stall  = !a_free;
  assign in_fire   = in_valid && a_free;
  assign good_fire = in_fire && !in_missed;
  assign group_done = good_fire && (sample_count_r == tktm_pkg::GROUP_LAST);

  // Keep only the configured sample bits.
  assign sample = tktm_pkg::TIME_W'(in_sample_time[tktm_pkg::SAMPLE_BITS-1:0]);

  assign upd_min = (sample < group_min_r) ? sample : group_min_r;
  assign upd_max = (sample > group_max_r) ? sample : group_max_r;
  assign upd_sum = group_sum_r + tktm_pkg::SUM_W'(sample);

  always_comb begin
    sample_count_nxt = sample_count_r;
    group_min_nxt    = group_min_r;
    group_max_nxt    = group_max_r;
    group_sum_nxt    = group_sum_r;
    if ((in_fire && in_missed) || group_done) begin
      // Drop the group on a miss, restart it after the tenth sample.
      sample_count_nxt = '0;
      group_min_nxt    = tktm_pkg::MIN_RESET;
      group_max_nxt    = '0;
      group_sum_nxt    = '0;
    end else if (good_fire) begin
      sample_count_nxt = sample_count_r + tktm_pkg::CNT_W'(1);
      group_min_nxt    = upd_min;
      group_max_nxt    = upd_max;
      group_sum_nxt    = upd_sum;
    end
  end

  always_comb begin
    a_valid_nxt   = group_done ? 1'b1 : (a_move ? 1'b0 : a_valid_r);
    b_valid_nxt   = a_move ? 1'b1 : (b_move ? 1'b0 : b_valid_r);
    out_valid_nxt = b_move || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= '0;
      group_min_r    <= tktm_pkg::MIN_RESET;
      group_max_r    <= '0;
      group_sum_r    <= '0;
      a_valid_r      <= 1'b0;
      b_valid_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      sample_count_r <= sample_count_nxt;
      group_min_r    <= group_min_nxt;
      group_max_r    <= group_max_nxt;
      group_sum_r    <= group_sum_nxt;
      a_valid_r      <= a_valid_nxt;
      b_valid_r      <= b_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Capture the closed group's totals, including the tenth sample.
  always_ff @(posedge clk) begin
    if (group_done) begin
      a_min_r <= upd_min;
      a_max_r <= upd_max;
      a_sum_r <= upd_sum;
    end
  end

  // Trim min and max off the sum.
  always_ff @(posedge clk) begin
    if (a_move) begin
      b_trim_r <= a_sum_r - tktm_pkg::SUM_W'(a_min_r) - tktm_pkg::SUM_W'(a_max_r);
    end
  end

  // Eight samples remain, so the mean is a shift and always fits 32 bits.
  assign mean = b_trim_r[tktm_pkg::TRIM_SHIFT +: tktm_pkg::TIME_W];

  always_ff @(posedge clk) begin
    if (b_move) begin
      out_time_r  <= mean;
      out_base_r  <= !calibrated_r;
      out_touch_r <= calibrated_r && ({1'b0, mean} > limit_r);
    end
  end

  // First result after reset becomes the baseline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calibrated_r <= 1'b0;
      baseline_r   <= '0;
    end else if (b_move && !calibrated_r) begin
      calibrated_r <= 1'b1;
      baseline_r   <= mean;
    end
  end

  // Threshold baseline + baseline/10, registered in tenth_prod_r and then
  // limit_r after the baseline is stored; it settles long before the next group can close.
  always_ff @(posedge clk) begin
    tenth_prod_r <= tktm_pkg::PROD_W'(baseline_r) * tktm_pkg::PROD_W'(tktm_pkg::RECIP_TEN);
    limit_r      <= tktm_pkg::LIMIT_W'(baseline_r)
                  + tktm_pkg::LIMIT_W'(tenth_prod_r[tktm_pkg::PROD_W-1:tktm_pkg::RECIP_SHIFT]);
  end

  assign out_valid         = out_valid_r;
  assign out_filtered_time = out_time_r;
  assign out_is_baseline   = out_base_r;
  assign out_touched       = out_touch_r;

  // A baseline beat never reports a touch.
  a_no_touch_on_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_base_r && out_touch_r))
    else $error("baseline beat flagged as touched");

  // Once a baseline beat is out, the block is calibrated.
  a_base_sets_cal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_base_r) |-> calibrated_r)
    else $error("baseline beat without calibration");

  // The group counter wraps before reaching the group size.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    sample_count_r < tktm_pkg::GROUP_SIZE)
    else $error("sample count out of range");

  // A missed capture restarts the group.
  a_miss_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_missed) |=> (sample_count_r == '0 && group_sum_r == '0))
    else $error("missed capture did not clear the group");

  // A partial group has min not above max.
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (sample_count_r != '0) |-> (group_min_r <= group_max_r))
    else $error("group min above group max");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the touch-key trimmed-mean detector.
`timescale 1ns / 1ps

module tb_top;

  // Run length and pacing.
  localparam int RAND_ITEMS  = 1250;
  localparam int PHASES      = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;     // idle tail after the last result beat
  localparam int GROUP_LEN   = 10;
  localparam int DIR_ROWS    = 24;

  // One result beat: trimmed mean plus the two decision flags.
  typedef struct packed {
    logic [tktm_pkg::TIME_W-1:0] filt;
    logic                        is_base;
    logic                        touched;
  } touch_res_t;

  // One row of the directed table; chk marks a row whose result is typed in.
  typedef struct packed {
    logic [tktm_pkg::TIME_W-1:0] smp;
    logic                        miss;
    logic                        chk;
    touch_res_t                  ex;
  } stim_row_t;

  // How the samples of one random group are spread.
  typedef enum int {
    SPREAD_NEAR,   // around the touch threshold of the directed baseline
    SPREAD_FLAT,   // ten equal samples, mean lands exactly on the value
    SPREAD_WIDE,   // full 32-bit range
    SPREAD_EDGE,   // zero, all ones, single bits set or cleared
    SPREAD_LOW     // small counts, below and above the baseline
  } spread_t;

  localparam touch_res_t NO_RES = '0;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [tktm_pkg::TIME_W-1:0] in_sample_time = '0;
  logic                        in_missed = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [tktm_pkg::TIME_W-1:0] out_filtered_time;
  logic                        out_is_baseline;
  logic                        out_touched;

  touch_key_trimmed_mean_detector dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_time   (in_sample_time),
    .in_missed        (in_missed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_filtered_time(out_filtered_time),
    .out_is_baseline  (out_is_baseline),
    .out_touched      (out_touched)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the group being gathered and the stored baseline.
  logic [tktm_pkg::CNT_W-1:0]  acc_cnt;
  logic [tktm_pkg::TIME_W-1:0] acc_min;
  logic [tktm_pkg::TIME_W-1:0] acc_max;
  logic [tktm_pkg::SUM_W-1:0]  acc_sum;
  logic [tktm_pkg::TIME_W-1:0] base_time;
  logic                        base_set;

  // Means still owed by the block, oldest first.
  touch_res_t pending_means[$];

  // Typed-in expectation for the beat on the ports, set with the beat.
  logic       row_chk = 1'b0;
  touch_res_t row_res = '0;

  int idle_pct  = 0;
  int stall_pct = 0;
  int beats_sent = 0;
  int mismatches = 0;
  int cycle_cnt  = 0;

  function automatic void clear_group();
    acc_cnt = '0;
    acc_min = tktm_pkg::MIN_RESET;
    acc_max = '0;
    acc_sum = '0;
  endfunction

  // Fold one accepted beat into the group; return 1 when it closes the group.
  function automatic bit fold_sample(input logic [tktm_pkg::TIME_W-1:0] raw,
                                     input logic miss,
                                     output touch_res_t res);
    logic [tktm_pkg::TIME_W-1:0] keep;
    logic [tktm_pkg::TIME_W-1:0] s;
    logic [tktm_pkg::SUM_W-1:0]  trimmed;
    logic [tktm_pkg::TIME_W-1:0] mean;
    logic [tktm_pkg::TIME_W:0]   limit;
    keep = tktm_pkg::TIME_W'((64'd1 << tktm_pkg::SAMPLE_BITS) - 64'd1);
    s = raw & keep;
    res = NO_RES;
    // A missed capture throws the partial group away; the baseline survives.
    if (miss) begin
      clear_group();
      return 1'b0;
    end
    if (s < acc_min) acc_min = s;
    if (s > acc_max) acc_max = s;
    acc_sum = acc_sum + tktm_pkg::SUM_W'(s);
    acc_cnt = acc_cnt + 1'b1;
    if (acc_cnt < tktm_pkg::CNT_W'(GROUP_LEN)) return 1'b0;
    // Trim the extremes, then divide the remaining eight by eight.
    trimmed = acc_sum - tktm_pkg::SUM_W'(acc_min) - tktm_pkg::SUM_W'(acc_max);
    mean = tktm_pkg::TIME_W'(trimmed >> 3);
    clear_group();
    res.filt = mean;
    if (!base_set) begin
      // First closed group becomes the baseline and never reports a touch.
      base_time = mean;
      base_set = 1'b1;
      res.is_base = 1'b1;
    end else begin
      // Threshold is formed one bit wider so a large baseline cannot wrap.
      limit = {1'b0, base_time} + {1'b0, base_time / tktm_pkg::TIME_W'(10)};
      res.touched = ({1'b0, mean} > limit);
    end
    return 1'b1;
  endfunction

  // Cycle count for the watchdog.
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // Receiver: stall at the falling edge at the rate of the current phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Monitor: both channels are observed at the rising edge, before the block's
  // registers move, so the values seen are the ones the handshake used.
  always @(posedge clk) begin
    touch_res_t got;
    touch_res_t want;
    touch_res_t calc;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_filtered_time, out_is_baseline, out_touched};
      if (pending_means.size() == 0) begin
        $error("result beat with nothing expected: filtered_time %0d", got.filt);
        mismatches++;
      end else begin
        want = pending_means.pop_front();
        if (got.filt !== want.filt) begin
          $error("filtered_time: expected %0d, got %0d", want.filt, got.filt);
          mismatches++;
        end
        if (got.is_base !== want.is_base) begin
          $error("is_baseline: expected %0b, got %0b", want.is_base, got.is_base);
          mismatches++;
        end
        if (got.touched !== want.touched) begin
          $error("touched: expected %0b, got %0b", want.touched, got.touched);
          mismatches++;
        end
      end
    end
    // Advance the predictor on every accepted input beat; a typed-in row
    // replaces the computed result but the state still advances.
    if (rst_n && in_valid && !in_stall) begin
      if (fold_sample(in_sample_time, in_missed, calc)) begin
        pending_means.push_back(row_chk ? row_res : calc);
      end
    end
  end

  // Offer one beat at the falling edge and hold it until accepted.
  task automatic send_beat(input logic [tktm_pkg::TIME_W-1:0] smp, input logic miss,
                           input logic chk, input touch_res_t ex);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_sample_time <= smp;
    in_missed      <= miss;
    row_chk = chk;
    row_res = ex;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // Hold the sender off until every owed result has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(negedge clk);
  endtask

  function automatic logic [tktm_pkg::TIME_W-1:0] pick_time(
      input spread_t sp, input logic [tktm_pkg::TIME_W-1:0] flat);
    logic [tktm_pkg::TIME_W-1:0] bit_one;
    bit_one = tktm_pkg::TIME_W'(1) << $urandom_range(0, tktm_pkg::TIME_W - 1);
    case (sp)
      SPREAD_NEAR: return tktm_pkg::TIME_W'($urandom_range(1040, 1160));
      SPREAD_FLAT: return flat;
      SPREAD_WIDE: return $urandom;
      SPREAD_EDGE: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return tktm_pkg::MIN_RESET;
          2: return bit_one;
          default: return ~bit_one;
        endcase
      end
      default: return tktm_pkg::TIME_W'($urandom_range(0, 2000));
    endcase
  endfunction

  // One group of ten with random content; now and then a missed capture
  // cuts it short so the next group starts from scratch.
  task automatic send_group();
    spread_t                     sp;
    logic [tktm_pkg::TIME_W-1:0] flat;
    int                          cut;
    sp   = spread_t'($urandom_range(0, 4));
    flat = tktm_pkg::TIME_W'(1098 + $urandom_range(0, 5));
    cut  = ($urandom_range(0, 99) < 12) ? $urandom_range(0, GROUP_LEN - 1) : -1;
    for (int k = 0; k < GROUP_LEN; k++) begin
      if (k == cut) begin
        send_beat($urandom, 1'b1, 1'b0, NO_RES);
        break;
      end
      send_beat(pick_time(sp, flat), 1'b0, 1'b0, NO_RES);
    end
  endtask

  // Directed rows: a partial group dropped by a missed capture, then a
  // baseline group whose extremes are trimmed (mean 1000), then a group of
  // all-ones samples that lands far above the threshold.
  stim_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{32'h1234_5678, 1'b0, 1'b0, NO_RES},
    '{32'h0000_0000, 1'b0, 1'b0, NO_RES},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
    '{32'hFFFF_FFFF, 1'b1, 1'b0, NO_RES},   // missed: sample is ignored
    '{32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
    '{32'd1000,      1'b0, 1'b0, NO_RES},
    '{32'd1000,      1'b0, 1'b0, NO_RES},
    '{32'd1000,      1'b0, 1'b0, NO_RES},
    '{32'd1000,      1'b0, 1'b0, NO_RES},
    '{32'h0000_0000, 1'b0, 1'b0, NO_RES},
    '{32'd1000,      1'b0, 1'b0, NO_RES},
    '{32'd1000,      1'b0, 1'b0, NO_RES},
    '{32'd1000,      1'b0, 1'b0, NO_RES},
    '{32'd1000,      1'b0, 1'b1, '{32'd1000, 1'b1, 1'b0}},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b1}}
  };

  // Idle and stall rates per phase: none, sender idle, receiver stall, both.
  int idle_tab  [PHASES] = '{0, 64, 0, 19};
  int stall_tab [PHASES] = '{0, 0, 64, 19};

  initial begin
    int phase_end;
    clear_group();
    base_time = '0;
    base_set  = 1'b0;

    // Hold reset low, then release it at a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_beat(dir_rows[r].smp, dir_rows[r].miss, dir_rows[r].chk, dir_rows[r].ex);
    end
    drain_results();

    // Random part, split over the idling phases; each phase ends with the
    // sender held off until the block has delivered everything it owes.
    for (int p = 0; p < PHASES; p++) begin
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      phase_end = beats_sent + RAND_ITEMS / PHASES;
      while (beats_sent < phase_end) begin
        // Occasional lone missed capture, often on an empty group.
        if ($urandom_range(0, 99) < 6) send_beat($urandom, 1'b1, 1'b0, NO_RES);
        else send_group();
      end
      drain_results();
    end

    stall_pct = 0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/tktm_pkg.sv
rtl/core/touch_key_trimmed_mean_detector.sv
verif/tb_top.sv
